@@ hdl/lkvc_pkg.sv @@
// Shared constants, types and helper functions for the LRU key-value cache.
package lkvc_pkg;

    // Number of entries in the fully associative store.
    localparam int ENTRIES = 16;

    // Derived widths: slot index, recency rank, and occupancy count.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    // Width wide enough to compare the register against the entry count.
    localparam int CAP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // Value of the active entry register after reset.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    // Operation codes.
    typedef enum logic
    {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    // One request word as held in the input register.
    typedef struct packed
    {
        kind_t                   kind;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] store_value;
    } req_t;

    // One response word as held in the result register.
    typedef struct packed
    {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } rsp_t;

    // Effective capacity: zero acts as one, anything above the store size is clamped.
    function automatic logic [CNT_W-1:0] capacity_of(input logic [CFG_W-1:0] active);
        logic [CAP_W-1:0] wide;
        logic [CAP_W-1:0] cap;
        begin
            wide = CAP_W'(active);
            cap = wide;
            if (wide == '0)
            begin
                cap = CAP_W'(1);
            end
            if (wide > CAP_W'(ENTRIES))
            begin
                cap = CAP_W'(ENTRIES);
            end
            return cap[CNT_W-1:0];
        end
    endfunction

endpackage

@@ hdl/lkvc_if.sv @@
// Handshake interfaces for the request, response and configuration channels.
interface lkvc_req_if
    import lkvc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    kind_t                   kind;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;

    modport source (output valid, output kind, output lookup_key, output store_value,
                    input ready);
    modport sink (input valid, input kind, input lookup_key, input store_value,
                  output ready);
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink (input valid, input found, input read_value, output ready);
endinterface

interface lkvc_cfg_if
    import lkvc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] active_entries;

    modport source (output valid, output active_entries, input ready);
    modport sink (input valid, input active_entries, output ready);
endinterface

@@ hdl/lru_key_value_cache_unit.sv @@
// Top level of the LRU key-value cache: input register, store and result register.
//
//   channel  dir  fields                                 word
//   req      in   kind, lookup_key, store_value          one get or put
//   rsp      out  found, read_value                      one result per request
//   cfg      in   active_entries                         capacity register write
//
// Each request sits in the input register, where the key match and the rank update
// happen, and moves on to the result register once that is free or being drained;
// one request per cycle is sustained while responses are taken, as the match is combinational.
// Reset clears all valid bits and sets the capacity register to sixteen; no clearing
// pass is needed. A stalled response holds the input register, and the request ready
// follows the response ready in the same cycle.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lkvc_req_if.sink   req,
    lkvc_rsp_if.source rsp,
    lkvc_cfg_if.sink   cfg
);

    logic             req_valid_reg;
    req_t             req_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    logic [CFG_W-1:0] active_reg;
    logic             fire;
    logic             req_take;
    rsp_t             rsp_next;
    logic [CNT_W-1:0] capacity;

    // Handshake: process when the result register is free or being drained.
    assign fire = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || fire;
    assign req_take = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign capacity = capacity_of(active_reg);

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg.valid)
        begin
            active_reg <= cfg.active_entries;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg.kind <= req.kind;
            req_reg.lookup_key <= req.lookup_key;
            req_reg.store_value <= req.store_value;
        end
    end

    // Entry store with match and replacement logic.
    lkvc_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req      (req_reg),
        .capacity (capacity),
        .rsp      (rsp_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.found = rsp_reg.found;
    assign rsp.read_value = rsp_reg.read_value;

endmodule

@@ hdl/lkvc_store.sv @@
// Entry storage with parallel key match, LRU rank update and replacement.
module lkvc_store
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  req_t             req,
    input  logic [CNT_W-1:0] capacity,
    output rsp_t             rsp
);

    // Entry payload has no reset; valid bits, ranks and count do.
    logic signed [KEY_W-1:0] keys_reg [ENTRIES];
    logic signed [VAL_W-1:0] values_reg [ENTRIES];
    logic [ENTRIES-1:0]      valid_reg;
    logic [ENTRIES-1:0]      valid_next;
    logic [RANK_W-1:0]       rank_reg [ENTRIES];
    logic [RANK_W-1:0]       rank_next [ENTRIES];
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;

    logic [ENTRIES-1:0]      hit_vec;
    logic                    hit_any;
    logic [IDX_W-1:0]        hit_idx;
    logic [ENTRIES-1:0]      victim_vec;
    logic [IDX_W-1:0]        victim_idx;
    logic [IDX_W-1:0]        free_idx;
    logic signed [VAL_W-1:0] hit_value;
    logic                    full;
    logic [CNT_W-1:0]        occ_last;
    logic                    update;
    logic                    write_entry;
    logic [IDX_W-1:0]        target;
    logic [CNT_W-1:0]        threshold;

    // Parallel key compare and priority picks (lowest slot wins).
    always_comb
    begin
        occ_last = occ_reg - CNT_W'(1);
        hit_any = 1'b0;
        hit_idx = '0;
        victim_idx = '0;
        free_idx = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (keys_reg[i] == req.lookup_key);
            victim_vec[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == occ_last);
            hit_value = hit_value | (hit_vec[i] ? values_reg[i] : '0);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (victim_vec[i])
            begin
                victim_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        hit_any = |hit_vec;
        full = (occ_reg >= capacity);
    end

    // Choose the entry to make most recent and the rank below which others age.
    always_comb
    begin
        update = 1'b0;
        write_entry = 1'b0;
        target = hit_idx;
        threshold = CNT_W'(rank_reg[hit_idx]);
        occ_next = occ_reg;
        if (hit_any)
        begin
            update = 1'b1;
            write_entry = (req.kind == KIND_PUT);
        end
        else if (req.kind == KIND_PUT)
        begin
            update = 1'b1;
            write_entry = 1'b1;
            if (full)
            begin
                target = victim_idx;
                threshold = occ_last;
            end
            else
            begin
                target = free_idx;
                threshold = occ_reg;
                occ_next = occ_reg + CNT_W'(1);
            end
        end
    end

    // Rank aging: valid entries more recent than the target move back one.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (valid_reg[i] && (IDX_W'(i) != target) && (CNT_W'(rank_reg[i]) < threshold))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
        rank_next[target] = '0;
        valid_next[target] = 1'b1;
    end

    // Response for the word being processed.
    always_comb
    begin
        rsp.found = hit_any;
        rsp.read_value = (hit_any && (req.kind == KIND_GET)) ? hit_value : '0;
    end

    // Control state: valid bits, ranks and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (fire && update)
        begin
            valid_reg <= valid_next;
            occ_reg <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Key and value storage, written at the target slot on a put.
    always_ff @(posedge clk)
    begin
        if (fire && write_entry)
        begin
            keys_reg[target] <= req.lookup_key;
            values_reg[target] <= req.store_value;
        end
    end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the LRU key-value cache unit.
module testbench
    import lkvc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run shape.
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_CAP_PHASE = 8;
    localparam int PAUSE_PHASE = 4;
    localparam int POOL_DEPTH = 24;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int LONG_HOLD_AFTER = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    // Field extremes.
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] ALL_ONES = 32'hffff_ffff;

    // Receiver ready patterns.
    typedef enum logic [1:0]
    {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_THIRD
    } ready_mode_t;

    // One row of the directed stimulus; a capacity write may precede the request.
    typedef struct packed
    {
        logic             set_cfg;
        logic [CFG_W-1:0] cfg_value;
        kind_t            kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             typed;
        rsp_t             typed_rsp;
    } step_row_t;

    logic clk;
    logic rst_n;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();
    lkvc_cfg_if cfg_ch ();

    lru_key_value_cache_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the store, the recency order and the capacity register.
    logic [KEY_W-1:0] shadow_key [ENTRIES];
    logic [VAL_W-1:0] shadow_val [ENTRIES];
    bit               shadow_valid [ENTRIES];
    int unsigned      shadow_rank [ENTRIES];
    int unsigned      shadow_count;
    logic [CFG_W-1:0] shadow_active;

    // Responses still owed by the block, oldest first.
    rsp_t expected_rsp [$];

    int mismatches;
    int requests_sent;
    int gets_sent;
    int puts_sent;
    int hits_seen;
    int cfg_writes;
    int burst_left;
    int idle_cycles;

    // Directed rows: extremes first, then capacity zero, one, past the store size and
    // back, with the smaller settings below the current occupancy.
    step_row_t directed_steps [NUM_DIRECTED] = '{
        '{1'b0, 5'd0,  KIND_GET, 32'h0,     32'h0,     1'b1, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_PUT, KEY_MAX,   KEY_MIN,   1'b1, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, KEY_MAX,   32'h0,     1'b1, '{1'b1, KEY_MIN}},
        '{1'b0, 5'd0,  KIND_PUT, KEY_MIN,   KEY_MAX,   1'b1, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, KEY_MIN,   ALL_ONES,  1'b1, '{1'b1, KEY_MAX}},
        '{1'b0, 5'd0,  KIND_PUT, KEY_MIN,   ALL_ONES,  1'b1, '{1'b1, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, KEY_MIN,   32'h0,     1'b1, '{1'b1, ALL_ONES}},
        '{1'b0, 5'd0,  KIND_GET, ALL_ONES,  32'h0,     1'b1, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_PUT, 32'h0,     32'h0,     1'b1, '{1'b0, 32'h0}},
        '{1'b1, 5'd0,  KIND_PUT, 32'd5,     32'd55,    1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, KEY_MAX,   32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'd5,     32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_PUT, 32'd6,     32'd66,    1'b0, '{1'b0, 32'h0}},
        '{1'b1, 5'd1,  KIND_PUT, 32'd7,     32'd77,    1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'd6,     32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b1, 5'd31, KIND_PUT, 32'd8,     32'd88,    1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_PUT, 32'd9,     32'd99,    1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'd8,     32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'd7,     32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b1, 5'd2,  KIND_PUT, 32'd10,    ALL_ONES,  1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'd9,     32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'd10,    32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b1, 5'd16, KIND_PUT, KEY_MAX,   32'd1,     1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, 32'h0,     32'h0,     1'b0, '{1'b0, 32'h0}},
        '{1'b0, 5'd0,  KIND_GET, KEY_MAX,   32'h0,     1'b0, '{1'b0, 32'h0}}
    };

    // Capacity setting of each random phase; one phase draws its own.
    logic [CFG_W-1:0] phase_caps [NUM_PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd15, 5'd17, 5'd0, 5'd2
    };

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Move one entry to the front of the recency order; entries ahead of it age by one.
    function automatic void make_most_recent(input int slot);
        int i;
        int unsigned old_rank;
        old_rank = shadow_rank[slot];
        for (i = 0; i < ENTRIES; i++)
        begin
            if (shadow_valid[i] && i != slot && shadow_rank[i] < old_rank)
            begin
                shadow_rank[i]++;
            end
        end
        shadow_rank[slot] = 0;
    endfunction

    // Apply one get or put to the shadow store and return the response it produces.
    function automatic rsp_t lru_access(input kind_t op, input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] value);
        int i;
        int hit;
        int victim;
        int slot;
        int unsigned cap;
        rsp_t result;
        hit = -1;
        victim = -1;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
            begin
                hit = i;
            end
        end
        result.found = (hit >= 0);
        result.read_value = '0;

        if (op == KIND_GET)
        begin
            if (hit >= 0)
            begin
                result.read_value = shadow_val[hit];
                make_most_recent(hit);
            end
            return result;
        end

        // Put on a present key updates in place.
        if (hit >= 0)
        begin
            shadow_val[hit] = value;
            make_most_recent(hit);
            return result;
        end

        // Zero acts as one, anything past the store size as the store size.
        cap = (shadow_active == '0) ? 1 : int'(shadow_active);
        if (cap > ENTRIES)
        begin
            cap = ENTRIES;
        end

        if (shadow_count >= cap)
        begin
            // Full, or shrunk below occupancy: overwrite the least recent entry.
            for (i = 0; i < ENTRIES; i++)
            begin
                if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                begin
                    victim = i;
                end
            end
            if (victim >= 0)
            begin
                shadow_key[victim] = key;
                shadow_val[victim] = value;
                make_most_recent(victim);
            end
        end
        else
        begin
            for (i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && !shadow_valid[i])
                begin
                    slot = i;
                end
            end
            if (slot >= 0)
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i])
                    begin
                        shadow_rank[i]++;
                    end
                end
                shadow_key[slot] = key;
                shadow_val[slot] = value;
                shadow_valid[slot] = 1'b1;
                shadow_rank[slot] = 0;
                shadow_count++;
            end
        end
        return result;
    endfunction

    // Count a failure and show the first few in detail.
    task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Offer one request word and hold it until accepted; valid stays high afterwards.
    task automatic send_request(input kind_t op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, input logic typed,
                                input rsp_t typed_rsp);
        rsp_t predicted;
        req_ch.valid <= 1'b1;
        req_ch.kind <= op;
        req_ch.lookup_key <= key;
        req_ch.store_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        predicted = lru_access(op, key, value);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        requests_sent++;
        if (op == KIND_GET)
        begin
            gets_sent++;
        end
        else
        begin
            puts_sent++;
        end
        if (predicted.found)
        begin
            hits_seen++;
        end
    endtask

    // Bursts of random length separated by random gaps, with some long unbroken runs.
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Stop offering and wait until every owed response has come back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_rsp.size() != 0);
    endtask

    // Write the capacity register; the block is idle when this is called.
    task automatic write_capacity(input logic [CFG_W-1:0] setting);
        cfg_ch.valid <= 1'b1;
        cfg_ch.active_entries <= setting;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_active = setting;
        cfg_writes++;
    endtask

    // Main stimulus: reset, directed rows, then random phases over several capacities.
    initial
    begin : stimulus
        int row;
        int phase;
        int n;
        int pool_size;
        logic [CFG_W-1:0] setting;
        logic [KEY_W-1:0] key_pool [POOL_DEPTH];
        logic [KEY_W-1:0] key;
        kind_t op;

        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_GET;
        req_ch.lookup_key <= '0;
        req_ch.store_value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.active_entries <= ACTIVE_RESET;
        for (n = 0; n < ENTRIES; n++)
        begin
            shadow_key[n] = '0;
            shadow_val[n] = '0;
            shadow_valid[n] = 1'b0;
            shadow_rank[n] = 0;
        end
        shadow_count = 0;
        shadow_active = ACTIVE_RESET;
        burst_left = $urandom_range(1, 20);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (row = 0; row < NUM_DIRECTED; row++)
        begin
            if (directed_steps[row].set_cfg)
            begin
                wait_for_drain();
                write_capacity(directed_steps[row].cfg_value);
            end
            send_request(directed_steps[row].kind, directed_steps[row].key,
                         directed_steps[row].value, directed_steps[row].typed,
                         directed_steps[row].typed_rsp);
            pace_sender();
        end

        // Random part: keys mostly from a small pool so that hits and evictions are common.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_drain();
            setting = (phase == RANDOM_CAP_PHASE) ? CFG_W'($urandom_range(0, 31))
                                                  : phase_caps[phase];
            write_capacity(setting);
            pool_size = $urandom_range(2, POOL_DEPTH);
            for (n = 0; n < POOL_DEPTH; n++)
            begin
                key_pool[n] = $urandom;
            end
            key_pool[0] = (phase % 2 == 0) ? KEY_MIN : KEY_MAX;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                begin
                    wait_for_drain();
                end
                op = kind_t'($urandom_range(0, 1));
                key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_size - 1)]
                                                   : KEY_W'($urandom);
                send_request(op, key, VAL_W'($urandom), 1'b0, '0);
                pace_sender();
            end
        end

        // Let the last responses come home.
        wait_for_drain();
        repeat (4) @(posedge clk);

        $display("Sent %0d requests (%0d gets, %0d puts), %0d of them found their key.",
                 requests_sent, gets_sent, puts_sent, hits_seen);
        $display("Capacity was rewritten %0d times, including zero, one, full and oversized.",
                 cfg_writes);
        if (mismatches == 0 && expected_rsp.size() == 0)
        begin
            $display("lru_key_value_cache_unit: match");
        end
        else
        begin
            $display("lru_key_value_cache_unit: mismatch");
        end
        $finish;
    end

    // Receiver: changing ready patterns, short random holds and one long hold.
    initial
    begin : receiver
        ready_mode_t mode;
        int mode_left;
        int hold_left;
        int rx_cycle;
        bit long_hold_done;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        rx_cycle = 0;
        long_hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && requests_sent >= LONG_HOLD_AFTER)
            begin
                // Long hold while the sender keeps offering, so the block backs up.
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                hold_left = $urandom_range(10, 40);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
                    default:   rsp_ch.ready <= (rx_cycle % 3 == 0);
                endcase
            end
        end
    end

    // Response check: each accepted word against the oldest owed response.
    always @(posedge clk)
    begin : response_check
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                flag_mismatch("response with no request waiting", '0, rsp_ch.read_value);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_ch.found !== want.found)
                begin
                    flag_mismatch("found", VAL_W'(want.found), VAL_W'(rsp_ch.found));
                end
                if (rsp_ch.read_value !== want.read_value)
                begin
                    flag_mismatch("read_value", want.read_value, rsp_ch.read_value);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with no handshake.", IDLE_LIMIT);
            $display("lru_key_value_cache_unit: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
hdl/lkvc_pkg.sv
hdl/lkvc_if.sv
hdl/lkvc_store.sv
hdl/lru_key_value_cache_unit.sv
verif/testbench.sv
